>>> hdl/rss_pkg.sv
// Shared types, register codes and constants of the reciprocating stroke sequencer.
package rss_pkg;

  // One input word: a control tick.
  typedef struct packed {
    logic        [15:0] event_status;
    logic signed [15:0] analog_sample;
    logic        [31:0] time_count;
    logic        [7:0]  host_mode;
  } rss_in_t;

  // One result word.
  typedef struct packed {
    logic               move_valid;
    logic signed [31:0] move_target;
    logic signed [31:0] velocity_command;
    logic        [2:0]  phase;
    logic               finished;
    logic        [1:0]  error_code;
  } rss_out_t;

  // Registers used by the stroke state machine.
  typedef struct packed {
    logic signed [31:0] end_position;
    logic signed [31:0] start_position;
    logic        [15:0] repetitions;
    logic        [31:0] dwell_ticks;
  } rss_cfg_t;

  // Base velocity split as quot * 14000 + rem.
  typedef struct packed {
    logic [17:0] quot;
    logic [13:0] rem;
  } rss_coef_t;

  // Sequencer result fields that travel down the pipeline.
  typedef struct packed {
    logic               move_valid;
    logic signed [31:0] move_target;
    logic        [2:0]  phase;
    logic               finished;
    logic        [1:0]  error_code;
  } rss_seq_t;

  typedef enum logic [2:0] {
    REG_END_POS   = 3'd0,
    REG_START_POS = 3'd1,
    REG_REPS      = 3'd2,
    REG_DWELL     = 3'd3,
    REG_BASE_VEL  = 3'd4
  } rss_reg_e;

  localparam int unsigned ADDR_W = 5;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_MOTION = 2'd1;
  localparam logic [1:0] ERR_LIMIT  = 2'd2;

  localparam logic [7:0]  MODE_START    = 8'h07;
  localparam logic [7:0]  MODE_RUN      = 8'h02;
  localparam logic [15:0] EVENT_MASK    = 16'h0071;
  localparam logic [15:0] EV_DONE       = 16'h0001;
  localparam logic [15:0] EV_MOTION_ERR = 16'h0010;
  localparam logic [15:0] EV_POS_LIMIT  = 16'h0020;
  localparam logic [15:0] EV_NEG_LIMIT  = 16'h0040;

  localparam logic signed [31:0] POS_HIGH = 32'sd17000;
  localparam logic signed [31:0] POS_LOW  = 32'sd50;

  localparam logic signed [31:0] END_POS_RST   = 32'sd17000;
  localparam logic signed [31:0] START_POS_RST = 32'sd50;
  localparam logic [15:0]        REPS_RST      = 16'd1;
  localparam logic [31:0]        DWELL_RST     = 32'd500;
  localparam logic [30:0]        BASE_VEL_RST  = 31'd0;

  localparam logic signed [16:0] KNOB_OFFSET = 17'sd7000;
  localparam logic [31:0]        VEL_DIV     = 32'd14000;

  // 14000 = 16 * 875. After dropping four bits, x / 875 is a multiply by
  // ceil(2^36 / 875) and a shift; the error term 139 keeps it exact for
  // any 27-bit operand.
  localparam logic [26:0] RECIP_MUL = 27'd78536545;

  // floor(x / 14000) for any 31-bit x.
  function automatic logic [17:0] div14000(input logic [30:0] x);
    logic [53:0] prod;
    prod = 54'(x[30:4]) * 54'(RECIP_MUL);
    return prod[53:36];
  endfunction

endpackage

>>> hdl/rss_cfg.sv
// Register file of the configuration port, with the split of the base velocity.
module rss_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rss_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output rss_pkg::rss_cfg_t               cfg_o,
  output rss_pkg::rss_coef_t              coef_o
);
  import rss_pkg::*;

  logic signed [31:0] end_q;
  logic signed [31:0] start_q;
  logic [15:0]        reps_q;
  logic [31:0]        dwell_q;
  logic [30:0]        base_q;
  logic [17:0]        quot_q;
  logic [13:0]        rem_q;
  logic [13:0]        rem_d;
  logic [31:0]        rem_full;
  logic               wr;
  rss_reg_e           reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = rss_reg_e'(paddr[ADDR_W-1:2]);

  // The remainder is registered from the quotient and follows it in the cycle after a base write.
  assign rem_full = 32'(base_q) - 32'(quot_q) * VEL_DIV;
  assign rem_d    = rem_full[13:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_q   <= END_POS_RST;
      start_q <= START_POS_RST;
      reps_q  <= REPS_RST;
      dwell_q <= DWELL_RST;
      base_q  <= BASE_VEL_RST;
      quot_q  <= div14000(BASE_VEL_RST);
      rem_q   <= '0;
    end else begin
      rem_q <= rem_d;
      if (wr) begin
        case (reg_idx)
          REG_END_POS:   end_q   <= $signed(pwdata);
          REG_START_POS: start_q <= $signed(pwdata);
          REG_REPS:      reps_q  <= pwdata[15:0];
          REG_DWELL:     dwell_q <= pwdata;
          REG_BASE_VEL: begin
            base_q <= pwdata[30:0];
            quot_q <= div14000(pwdata[30:0]);
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_END_POS:   prdata = end_q;
      REG_START_POS: prdata = start_q;
      REG_REPS:      prdata = 32'(reps_q);
      REG_DWELL:     prdata = dwell_q;
      REG_BASE_VEL:  prdata = 32'(base_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.end_position   = end_q;
  assign cfg_o.start_position = start_q;
  assign cfg_o.repetitions    = reps_q;
  assign cfg_o.dwell_ticks    = dwell_q;
  assign coef_o.quot          = quot_q;
  assign coef_o.rem           = rem_q;

endmodule

>>> hdl/rss_seq.sv
// Stroke state machine: phases, dwell timing, stroke count and run end.
module rss_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  rss_pkg::rss_in_t    in_i,
  input  rss_pkg::rss_cfg_t   cfg_i,
  output rss_pkg::rss_seq_t   res_o
);
  import rss_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_OUT         = 3'd1,
    PH_OUTER_DWELL = 3'd2,
    PH_RETURN      = 3'd3,
    PH_INNER_DWELL = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d, next_phase;
  logic        entry_q, entry_d;
  logic        latch_q, latch_d;
  logic [31:0] dws_q, dws_d;
  logic [15:0] count_q, count_d;
  logic        ended_q, ended_d;
  logic [1:0]  err_q, err_d;

  logic               ending;
  logic               move;
  logic signed [31:0] target;
  logic [31:0]        elapsed;
  logic [15:0]        count_inc;

  always_comb begin
    next_phase = phase_q;
    entry_d    = entry_q;
    latch_d    = latch_q;
    dws_d      = dws_q;
    count_d    = count_q;
    err_d      = err_q;
    ending     = 1'b0;
    move       = 1'b0;
    target     = '0;
    elapsed    = in_i.time_count - (entry_q ? in_i.time_count : dws_q);
    count_inc  = (count_q != 16'hFFFF) ? count_q + 16'd1 : count_q;

    if (!ended_q) begin
      case (phase_q)
        PH_IDLE: begin
          if (latch_q) begin
            latch_d    = 1'b0;
            next_phase = PH_OUT;
          end
        end
        PH_OUT, PH_RETURN: begin
          if (entry_q) begin
            move    = 1'b1;
            entry_d = 1'b0;
            if (phase_q == PH_OUT) begin
              target = (cfg_i.end_position > POS_HIGH) ? POS_HIGH : cfg_i.end_position;
            end else begin
              target = (cfg_i.start_position < POS_LOW) ? POS_LOW : cfg_i.start_position;
            end
          end
          // Any event of interest re-arms the move; only exact codes act.
          if ((in_i.event_status & EVENT_MASK) != '0) begin
            entry_d = 1'b1;
            if (in_i.event_status == EV_DONE) begin
              next_phase = (phase_q == PH_OUT) ? PH_OUTER_DWELL : PH_INNER_DWELL;
            end else if (in_i.event_status == EV_MOTION_ERR) begin
              ending = 1'b1;
              err_d  = ERR_MOTION;
            end else if ((phase_q == PH_OUT && in_i.event_status == EV_POS_LIMIT) ||
                         (phase_q == PH_RETURN && in_i.event_status == EV_NEG_LIMIT)) begin
              ending = 1'b1;
              err_d  = ERR_LIMIT;
            end
          end
        end
        PH_OUTER_DWELL, PH_INNER_DWELL: begin
          if (entry_q) begin
            dws_d   = in_i.time_count;
            entry_d = 1'b0;
          end
          if (elapsed >= cfg_i.dwell_ticks) begin
            entry_d = 1'b1;
            if (phase_q == PH_OUTER_DWELL) begin
              next_phase = PH_RETURN;
            end else begin
              next_phase = PH_OUT;
              count_d    = count_inc;
            end
          end
        end
        default: next_phase = PH_IDLE;
      endcase

      if (count_d >= cfg_i.repetitions) ending = 1'b1;
      if (in_i.host_mode == MODE_START) latch_d = 1'b1;
      if (in_i.host_mode != MODE_RUN && in_i.host_mode != MODE_START) ending = 1'b1;
    end

    ended_d = ended_q || ending;
    phase_d = ending ? phase_q : next_phase;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      entry_q <= 1'b1;
      latch_q <= 1'b1;
      dws_q   <= '0;
      count_q <= '0;
      ended_q <= 1'b0;
      err_q   <= ERR_NONE;
    end else if (step_i) begin
      phase_q <= phase_d;
      entry_q <= entry_d;
      latch_q <= latch_d;
      dws_q   <= dws_d;
      count_q <= count_d;
      ended_q <= ended_d;
      err_q   <= err_d;
    end
  end

  assign res_o.move_valid  = move;
  assign res_o.move_target = target;
  assign res_o.phase       = phase_d;
  assign res_o.finished    = ended_d;
  assign res_o.error_code  = err_d;

endmodule

>>> hdl/rss_vel.sv
// Knob-scaled velocity: two register stages of products and a reciprocal divide.
module rss_vel (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [15:0]        sample_i,
  input  rss_pkg::rss_coef_t        coef_i,
  output logic signed [31:0]        vel_o
);
  import rss_pkg::*;

  logic signed [16:0] knob;
  logic        [16:0] knob_neg;
  logic        [15:0] knob_mag;
  logic        [17:0] lo_full;
  logic        [34:0] mag;

  logic [33:0] hi2_q;
  logic [29:0] lo2_q;
  logic        neg2_q;
  logic [33:0] hi3_q;
  logic [15:0] lo3_q;
  logic        neg3_q;

  // The velocity is sign times floor(base * |knob| / 14000), which is
  // quot * |knob| plus floor(rem * |knob| / 14000).
  assign knob     = $signed({sample_i[15], sample_i}) + KNOB_OFFSET;
  assign knob_neg = 17'(-knob);
  assign knob_mag = knob[16] ? knob_neg[15:0] : knob[15:0];
  assign lo_full  = div14000(31'(lo2_q));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi2_q  <= 34'(coef_i.quot) * 34'(knob_mag);
      lo2_q  <= 30'(coef_i.rem) * 30'(knob_mag);
      neg2_q <= knob[16];
      hi3_q  <= hi2_q;
      lo3_q  <= lo_full[15:0];
      neg3_q <= neg2_q;
    end
  end

  assign mag = 35'(hi3_q) + 35'(lo3_q);

  always_comb begin
    if (neg3_q) begin
      vel_o = (mag >= 35'h080000000) ? 32'sh80000000 : $signed(-mag[31:0]);
    end else begin
      vel_o = (mag > 35'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(mag[31:0]);
    end
  end

endmodule

>>> hdl/reciprocating_stroke_sequencer.sv
// Top level: input register, sequencer, velocity stages and output register.
// Throughput: one word per cycle; the four register stages (input, products,
// reciprocal divide, output) all advance together whenever the output
// register is empty or being taken.
// Reset: asynchronous, active low; clears the pipeline and the sequencer to
// idle with start latched, and loads the register defaults.
module reciprocating_stroke_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rss_pkg::rss_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rss_pkg::rss_out_t            out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rss_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import rss_pkg::*;

  logic               en;
  logic               v1_q, v2_q, v3_q, v4_q;
  rss_in_t            in_q;
  rss_seq_t           seq_res;
  rss_seq_t           seq2_q, seq3_q;
  rss_out_t           out_q;
  rss_cfg_t           cfg;
  rss_coef_t          coef;
  logic signed [31:0] vel;

  // The whole pipeline moves unless a finished word is held at the output.
  assign en         = !(v4_q && out_stall_i);
  assign in_stall_o = !en;

  rss_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .coef_o  (coef)
  );

  rss_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (v1_q && en),
    .in_i   (in_q),
    .cfg_i  (cfg),
    .res_o  (seq_res)
  );

  rss_vel u_vel (
    .clk_i    (clk_i),
    .en_i     (en),
    .sample_i (in_q.analog_sample),
    .coef_i   (coef),
    .vel_o    (vel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q                   <= in_data_i;
      seq2_q                 <= seq_res;
      seq3_q                 <= seq2_q;
      out_q.move_valid       <= seq3_q.move_valid;
      out_q.move_target      <= seq3_q.move_target;
      out_q.velocity_command <= vel;
      out_q.phase            <= seq3_q.phase;
      out_q.finished         <= seq3_q.finished;
      out_q.error_code       <= seq3_q.error_code;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/rss_chk.sv
// Port-level checker for the stroke sequencer, bound to the top level.
module rss_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rss_pkg::rss_out_t   out_data_o
);
  import rss_pkg::*;

  logic seen_fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_fin_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && out_data_o.finished) begin
      seen_fin_q <= 1'b1;
    end
  end

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Without a move the target reads as zero.
  a_no_move_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.move_valid |-> out_data_o.move_target == '0)
    else $error("target shown without a move");

  // An error code only comes with the end of the run.
  a_err_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_code != ERR_NONE |-> out_data_o.finished)
    else $error("error code on a running stroke");

  // Once the run has ended it stays ended, with no further moves.
  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_fin_q |-> out_data_o.finished && !out_data_o.move_valid)
    else $error("run resumed after it ended");

endmodule

bind reciprocating_stroke_sequencer rss_chk u_rss_chk (.*);

>>> dv/testbench.sv
// Self-checking testbench of the stroke sequencer: random ticks against a predictor.
module testbench;
  import rss_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_OUT         = 3'd1,
    PH_OUTER_DWELL = 3'd2,
    PH_RETURN      = 3'd3,
    PH_INNER_DWELL = 3'd4
  } stroke_phase_e;

  typedef enum int {
    END_REPS_ZERO,
    END_REPS_MET,
    END_MOTION,
    END_LIMIT,
    END_HOST
  } finale_e;

  typedef struct packed {
    stroke_phase_e phase;
    logic          rearm;
    logic          start_held;
    logic [31:0]   dwell_t0;
    logic [15:0]   strokes;
    logic          over;
    logic [1:0]    err;
  } stroke_state_t;

  typedef struct packed {
    logic signed [31:0] end_pos;
    logic signed [31:0] start_pos;
    logic        [15:0] reps;
    logic        [31:0] dwell;
    logic        [30:0] base;
  } stroke_cfg_t;

  localparam longint VEL_MAX = 64'sd2147483647;
  localparam longint VEL_MIN = -64'sd2147483648;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        tick_valid = 1'b0;
  logic        in_stall;
  rss_in_t     tick_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rss_out_t    out_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stroke_cfg_t   regs;
  stroke_state_t live_st;
  stroke_state_t plan_st;
  rss_in_t       tick_q[$];
  rss_out_t      predicted_words[$];
  rss_out_t      want_word;
  rss_out_t      scratch_word;
  logic [31:0]   clock_now = '0;
  int            ticks_owed = 0;
  int            fault_count = 0;
  int            idle_odds = 0;
  int            gap_left = 0;
  int            stall_left = 0;
  logic          took_tick = 1'b0;

  reciprocating_stroke_sequencer DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (tick_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (tick_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 400000);
    $display("testbench: done, errors");
    $finish;
  end

  // One control tick of the sequencer; returns the result word it causes.
  function automatic rss_out_t advance_stroke(inout stroke_state_t st, input stroke_cfg_t cfg,
                                              input rss_in_t t);
    rss_out_t      r;
    stroke_phase_e nxt;
    logic          ending;
    logic [31:0]   waited;
    longint        prod;
    longint        vel;
    r = '0;
    nxt = st.phase;
    ending = 1'b0;
    prod = longint'(cfg.base) * (longint'(t.analog_sample) + longint'(KNOB_OFFSET));
    vel = prod / longint'(VEL_DIV);
    if (vel > VEL_MAX) vel = VEL_MAX;
    if (vel < VEL_MIN) vel = VEL_MIN;
    if (!st.over) begin
      case (st.phase)
        PH_IDLE: begin
          if (st.start_held) begin
            st.start_held = 1'b0;
            nxt = PH_OUT;
          end
        end
        PH_OUT, PH_RETURN: begin
          if (st.rearm) begin
            r.move_valid = 1'b1;
            if (st.phase == PH_OUT)
              r.move_target = (cfg.end_pos > POS_HIGH) ? POS_HIGH : cfg.end_pos;
            else
              r.move_target = (cfg.start_pos < POS_LOW) ? POS_LOW : cfg.start_pos;
            st.rearm = 1'b0;
          end
          // Any axis event re-issues the move; only exact codes change the phase.
          if ((t.event_status & EVENT_MASK) != '0) begin
            st.rearm = 1'b1;
            if (t.event_status == EV_DONE) begin
              nxt = (st.phase == PH_OUT) ? PH_OUTER_DWELL : PH_INNER_DWELL;
            end else if (t.event_status == EV_MOTION_ERR) begin
              ending = 1'b1;
              st.err = ERR_MOTION;
            end else if ((st.phase == PH_OUT && t.event_status == EV_POS_LIMIT) ||
                         (st.phase == PH_RETURN && t.event_status == EV_NEG_LIMIT)) begin
              ending = 1'b1;
              st.err = ERR_LIMIT;
            end
          end
        end
        PH_OUTER_DWELL, PH_INNER_DWELL: begin
          if (st.rearm) begin
            st.dwell_t0 = t.time_count;
            st.rearm = 1'b0;
          end
          waited = t.time_count - st.dwell_t0;
          if (waited >= cfg.dwell) begin
            st.rearm = 1'b1;
            if (st.phase == PH_OUTER_DWELL) begin
              nxt = PH_RETURN;
            end else begin
              nxt = PH_OUT;
              if (st.strokes != 16'hFFFF) st.strokes = st.strokes + 16'd1;
              if (st.strokes >= cfg.reps) begin
                ending = 1'b1;
                nxt = PH_INNER_DWELL;
              end
            end
          end
        end
        default: nxt = PH_IDLE;
      endcase
      if (st.strokes >= cfg.reps) ending = 1'b1;
      if (t.host_mode == MODE_START) st.start_held = 1'b1;
      if (t.host_mode != MODE_RUN && t.host_mode != MODE_START) ending = 1'b1;
      if (ending) st.over = 1'b1;
      else st.phase = nxt;
    end
    r.velocity_command = vel[31:0];
    r.phase = st.phase;
    r.finished = st.over;
    r.error_code = st.err;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fault_count++;
    end
  endtask

  task automatic read_reg(input rss_reg_e idx, input logic [31:0] want);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("register readback", want, prdata);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_reg(input rss_reg_e idx, input logic [31:0] val);
    logic [31:0] held;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    held = val;
    case (idx)
      REG_END_POS:   regs.end_pos = val;
      REG_START_POS: regs.start_pos = val;
      REG_REPS: begin
        regs.reps = val[15:0];
        held = {16'h0000, val[15:0]};
      end
      REG_DWELL:     regs.dwell = val;
      default: begin
        regs.base = val[30:0];
        held = {1'b0, val[30:0]};
      end
    endcase
    read_reg(idx, held);
  endtask

  // The planning copy of the state steers the generator toward deep sequences.
  task automatic queue_tick(input logic [15:0] status, input logic signed [15:0] knob,
                            input logic [31:0] stamp, input logic [7:0] mode);
    rss_in_t t;
    t.event_status = status;
    t.analog_sample = knob;
    t.time_count = stamp;
    t.host_mode = mode;
    scratch_word = advance_stroke(plan_st, regs, t);
    tick_q.push_back(t);
    ticks_owed++;
  endtask

  function automatic logic signed [15:0] pick_knob();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return -16'sd7000 + 16'($urandom_range(0, 2)) - 16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_target(input logic [31:0] center);
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return center - 32'd1;
      3: return center;
      4: return center + 32'd1;
      5: return $urandom_range(0, 20000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] move_status(input stroke_phase_e ph);
    logic [15:0] s;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: s = '0;
      6: s = 16'($urandom) & ~EVENT_MASK;
      7, 8, 9, 10, 11, 12, 13: s = EV_DONE;
      14, 15, 16, 17: begin
        s = 16'($urandom);
        if ((s & EVENT_MASK) == '0) s = s | EV_DONE;
        // Keep the word a re-issue: flip a bit outside the event mask.
        if (s == EV_MOTION_ERR || (ph == PH_OUT && s == EV_POS_LIMIT) ||
            (ph == PH_RETURN && s == EV_NEG_LIMIT))
          s = s ^ 16'h0100;
      end
      default: s = (ph == PH_OUT) ? EV_NEG_LIMIT : EV_POS_LIMIT;
    endcase
    return s;
  endfunction

  task automatic queue_random_tick();
    logic [15:0] status;
    logic [7:0]  mode;
    clock_now = clock_now + 32'($urandom_range(0, 4));
    if ($urandom_range(0, 40) == 0) clock_now = $urandom;
    if ((plan_st.phase == PH_OUTER_DWELL || plan_st.phase == PH_INNER_DWELL) &&
        $urandom_range(0, 5) == 0)
      clock_now = plan_st.dwell_t0 + regs.dwell - 32'($urandom_range(0, 1));
    if (plan_st.phase == PH_OUT || plan_st.phase == PH_RETURN)
      status = move_status(plan_st.phase);
    else
      status = 16'($urandom);
    mode = ($urandom_range(0, 4) == 0) ? MODE_START : MODE_RUN;
    queue_tick(status, pick_knob(), clock_now, mode);
  endtask

  task automatic wait_drained();
    while (ticks_owed != 0 || predicted_words.size() != 0) @(negedge clk);
  endtask

  // Driver: presents queued tick words, with random bursts of idle cycles.
  always @(negedge clk) begin
    if (!rst_n) begin
      tick_valid <= 1'b0;
    end else if (!tick_valid || took_tick) begin
      if (gap_left > 0) begin
        gap_left--;
        tick_valid <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        gap_left = $urandom_range(1, 16) - 1;
        tick_valid <= 1'b0;
      end else if (tick_q.size() > 0) begin
        tick_valid <= 1'b1;
        tick_data <= tick_q.pop_front();
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predicts on each accepted tick and checks each accepted result word.
  always @(posedge clk) begin
    took_tick = rst_n && tick_valid && !in_stall;
    if (took_tick) begin
      want_word = advance_stroke(live_st, regs, tick_data);
      predicted_words.push_back(want_word);
      ticks_owed--;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_words.size() == 0) begin
        $display("%0t: result word with none predicted, expected nothing, actual %h",
                 $time, out_word);
        fault_count++;
      end else begin
        want_word = predicted_words.pop_front();
        check_field("move_valid", 32'(want_word.move_valid), 32'(out_word.move_valid));
        check_field("move_target", want_word.move_target, out_word.move_target);
        check_field("velocity_command", want_word.velocity_command,
                    out_word.velocity_command);
        check_field("phase", 32'(want_word.phase), 32'(out_word.phase));
        check_field("finished", 32'(want_word.finished), 32'(out_word.finished));
        check_field("error_code", 32'(want_word.error_code), 32'(out_word.error_code));
      end
    end
  end

  initial begin : stimulus
    finale_e finale;
    logic    moving;
    logic [7:0] stop_mode;
    int      n;
    regs = '{END_POS_RST, START_POS_RST, REPS_RST, DWELL_RST, BASE_VEL_RST};
    live_st = '0;
    live_st.phase = PH_IDLE;
    live_st.rearm = 1'b1;
    live_st.start_held = 1'b1;
    plan_st = live_st;
    idle_odds = 4;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    read_reg(REG_END_POS, END_POS_RST);
    read_reg(REG_START_POS, START_POS_RST);
    read_reg(REG_REPS, 32'(REPS_RST));
    read_reg(REG_DWELL, DWELL_RST);
    read_reg(REG_BASE_VEL, 32'(BASE_VEL_RST));

    // Clamped targets, zero dwell and saturating velocity.
    write_reg(REG_END_POS, 32'h7FFF_FFFF);
    write_reg(REG_START_POS, 32'h8000_0000);
    write_reg(REG_REPS, 32'd65535);
    write_reg(REG_DWELL, 32'd0);
    write_reg(REG_BASE_VEL, 32'h7FFF_FFFF);
    queue_tick(16'h0000, 16'sh7FFF, 32'd0, MODE_RUN);
    queue_tick(16'hFFFF, 16'sh8000, 32'd1, MODE_START);
    queue_tick(EV_NEG_LIMIT, -16'sd7000, 32'd2, MODE_RUN);
    queue_tick(16'h0000, -16'sd6999, 32'd3, MODE_RUN);
    queue_tick(16'hFFFF & ~EVENT_MASK, -16'sd7001, 32'd4, MODE_RUN);
    queue_tick(EV_DONE, 16'sd0, 32'hFFFF_FFF0, MODE_RUN);
    queue_tick(16'hFFFF, 16'sd1, 32'hFFFF_FFF0, MODE_RUN);
    queue_tick(16'h0000, 16'sd100, 32'hFFFF_FFF1, MODE_RUN);
    queue_tick(EV_POS_LIMIT, 16'sd200, 32'hFFFF_FFF2, MODE_RUN);
    queue_tick(EV_DONE, 16'sd300, 32'hFFFF_FFF3, MODE_START);
    queue_tick(16'h0000, -16'sd300, 32'd2, MODE_RUN);
    wait_drained();

    // Unclamped targets and a dwell that only ends on a full wrap of the counter.
    write_reg(REG_END_POS, 32'h8000_0000);
    write_reg(REG_START_POS, 32'h7FFF_FFFF);
    write_reg(REG_DWELL, 32'hFFFF_FFFF);
    write_reg(REG_BASE_VEL, 32'd14000);
    queue_tick(16'h0000, 16'sd5, 32'd100, MODE_RUN);
    queue_tick(EV_DONE, -16'sd5, 32'd101, MODE_RUN);
    queue_tick(16'h0000, 16'sd7, 32'd200, MODE_RUN);
    queue_tick(16'h0000, -16'sd7, 32'h7FFF_FFFF, MODE_RUN);
    queue_tick(16'h0000, 16'sd9, 32'd199, MODE_RUN);
    queue_tick(16'h0000, -16'sd9, 32'd300, MODE_RUN);
    queue_tick(EV_DONE, 16'sd11, 32'd301, MODE_RUN);
    queue_tick(16'h0000, -16'sd11, 32'd200, MODE_RUN);
    queue_tick(16'h0000, 16'sd13, 32'd199, MODE_RUN);

    clock_now = 32'hFFFF_FF00;
    for (n = 0; n < 12; n++) begin
      wait_drained();
      idle_odds = (n % 3 == 2) ? 0 : ((n % 3 == 0) ? 3 : 8);
      write_reg(REG_END_POS, pick_target(32'd17000));
      write_reg(REG_START_POS, pick_target(32'd50));
      write_reg(REG_REPS, {16'($urandom), 16'($urandom_range(300, 65535))});
      case ($urandom_range(0, 5))
        0: write_reg(REG_DWELL, 32'd0);
        1: write_reg(REG_DWELL, 32'hFFFF_FFFF);
        2: write_reg(REG_DWELL, $urandom);
        default: write_reg(REG_DWELL, $urandom_range(0, 12));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(REG_BASE_VEL, 32'd0);
        1: write_reg(REG_BASE_VEL, 32'h7FFF_FFFF);
        2: write_reg(REG_BASE_VEL, $urandom_range(0, 20000));
        default: write_reg(REG_BASE_VEL, $urandom);
      endcase
      repeat (52) queue_random_tick();
    end

    // Last part: no idling, end the run one way, then frozen-state ticks.
    wait_drained();
    idle_odds = 0;
    finale = finale_e'($urandom_range(0, 4));
    write_reg(REG_DWELL, $urandom_range(0, 8));
    write_reg(REG_BASE_VEL, $urandom_range(1, 32'h7FFF_FFFF));
    if (finale == END_REPS_ZERO) write_reg(REG_REPS, 32'd0);
    if (finale == END_REPS_MET) write_reg(REG_REPS, 32'(plan_st.strokes) + 32'd1);
    for (n = 0; n < 400 && !plan_st.over; n++) begin
      moving = plan_st.phase == PH_OUT || plan_st.phase == PH_RETURN;
      if (finale == END_MOTION && moving) begin
        queue_tick(EV_MOTION_ERR, pick_knob(), clock_now, MODE_RUN);
      end else if (finale == END_LIMIT && moving) begin
        queue_tick((plan_st.phase == PH_OUT) ? EV_POS_LIMIT : EV_NEG_LIMIT, pick_knob(),
                   clock_now, MODE_RUN);
      end else if (finale == END_HOST && $urandom_range(0, 3) == 0) begin
        stop_mode = 8'($urandom);
        if (stop_mode == MODE_RUN || stop_mode == MODE_START) stop_mode = stop_mode ^ 8'h80;
        queue_tick(16'($urandom), pick_knob(), clock_now, stop_mode);
      end else begin
        queue_random_tick();
      end
    end
    repeat (40) queue_tick(16'($urandom), 16'($urandom), $urandom, 8'($urandom));

    wait_drained();
    repeat (12) @(posedge clk);
    if (fault_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
